// ===== hw/rtl/bia_pkg.sv =====
// Package for the bitmap index allocator.
// Holds field widths, parameter defaults, operation and state codes, and the
// command and status structs shared by the controller and the datapath.
package bia_pkg;

    localparam int MAX_SLOTS_DEF = 256;
    localparam int WORD_BITS_DEF = 8;

    localparam int SLOT_W = 8;
    localparam int CFG_W  = 9;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

// ===== hw/rtl/bia_if.sv =====
// Channel interfaces of the bitmap index allocator.
// Request, response and configuration channels; depends on bia_pkg.
interface bia_req_if import bia_pkg::*; ();
    logic              valid;
    logic              ready;
    op_t               func;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output func, output slot_index, input ready);
    modport sink (input valid, input func, input slot_index, output ready);
endinterface

interface bia_rsp_if import bia_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [SLOT_W-1:0] granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink (input valid, input status, input granted_index, output ready);
endinterface

interface bia_cfg_if import bia_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] slots_in_use;

    modport source (output valid, output slots_in_use, input ready);
    modport sink (input valid, input slots_in_use, output ready);
endinterface

// ===== hw/rtl/bitmap_index_allocator_core.sv =====
// A result is registered after the load, map-read and evaluate states;
// evaluate holds while an earlier result is still waiting. Items go one at
// a time through the map RAM read and the read-modify-write of one map word
// per item; a free word is found from per-word full flags.
// Reset clears the whole map at once through per-word used flags.
// Depends on bia_pkg, bia_if, bia_ctrl and bia_datapath.
module bitmap_index_allocator_core import bia_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    bia_req_if.sink  req,
    bia_rsp_if.source rsp,
    bia_cfg_if.sink  cfg
);

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    bia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bia_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (req.func),
        .slot_index    (req.slot_index),
        .cfg_valid     (cfg.valid),
        .cfg_data      (cfg.slots_in_use),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .status        (rsp.status),
        .granted_index (rsp.granted_index)
    );

endmodule

// ===== hw/rtl/bia_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bia_ctrl.sv =====
// Controller state machine of the bitmap index allocator.
// Sequences load, map read and commit; depends on bia_pkg.
module bia_ctrl import bia_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bia_datapath.sv =====
// Datapath of the bitmap index allocator: map RAM, per-word used and full
// flags, slot count register, search logic and the result register.
// Depends on bia_pkg and bia_ram.
module bia_datapath import bia_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  op_t               func,
    input  logic [SLOT_W-1:0] slot_index,
    input  logic              cfg_valid,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              status,
    output logic [SLOT_W-1:0] granted_index
);

    localparam int MAP_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int TOTAL     = MAP_WORDS * WORD_BITS;
    localparam int CMP_W     = ($clog2(TOTAL + 1) > CFG_W) ? $clog2(TOTAL + 1) : CFG_W;
    localparam int TAB_N     = 2 ** SLOT_W;
    localparam logic [WORD_BITS-1:0] ONE_BIT = WORD_BITS'(1);

    logic [CFG_W-1:0]     cfg_reg;
    logic [MAP_WORDS-1:0] used_reg;
    logic [MAP_WORDS-1:0] full_reg;
    op_t                  op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic                 pre_fail_reg;
    logic                 out_valid_reg;
    logic                 status_reg;
    logic [SLOT_W-1:0]    granted_reg;

    logic [ADDR_W-1:0]    word_tab [TAB_N];
    logic [BIT_W-1:0]     bit_tab [TAB_N];

    logic [CMP_W-1:0]     limit;
    logic [ADDR_W-1:0]    free_word;
    logic                 any_free_word;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] cur_word;
    logic [BIT_W-1:0]     zero_bit;
    logic [CMP_W-1:0]     alloc_idx;
    logic [WORD_BITS-1:0] new_word;
    logic                 fail;

    for (genvar g = 0; g < TAB_N; g++)
    begin : g_tab
        assign word_tab[g] = ADDR_W'(g / WORD_BITS);
        assign bit_tab[g]  = BIT_W'(g % WORD_BITS);
    end

    assign limit = (CMP_W'(cfg_reg) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS)
                                                         : CMP_W'(cfg_reg);

    always_comb
    begin
        free_word     = '0;
        any_free_word = 1'b0;
        for (int i = MAP_WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                free_word     = ADDR_W'(i);
                any_free_word = 1'b1;
            end
        end
    end

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (cmd.commit && !fail),
        .waddr (addr_reg),
        .wdata (new_word),
        .re    (cmd.rd),
        .raddr (addr_reg),
        .rdata (rd_word)
    );

    always_comb
    begin
        cur_word = used_reg[addr_reg] ? rd_word : '0;
        zero_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!cur_word[b])
            begin
                zero_bit = BIT_W'(b);
            end
        end
        alloc_idx = CMP_W'(addr_reg) * CMP_W'(WORD_BITS) + CMP_W'(zero_bit);
        if (op_reg == OP_FREE)
        begin
            new_word = cur_word & ~(ONE_BIT << bit_reg);
            fail     = pre_fail_reg || !cur_word[bit_reg];
        end
        else
        begin
            new_word = cur_word | (ONE_BIT << zero_bit);
            fail     = pre_fail_reg || (alloc_idx >= limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            used_reg      <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.commit && !fail)
            begin
                used_reg[addr_reg] <= 1'b1;
                full_reg[addr_reg] <= &new_word;
            end
            out_valid_reg <= cmd.commit || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= func;
            if (func == OP_FREE)
            begin
                addr_reg     <= word_tab[slot_index];
                bit_reg      <= bit_tab[slot_index];
                pre_fail_reg <= CMP_W'(slot_index) >= limit;
            end
            else
            begin
                addr_reg     <= free_word;
                bit_reg      <= '0;
                pre_fail_reg <= !any_free_word;
            end
        end
        if (cmd.commit)
        begin
            status_reg  <= fail;
            granted_reg <= (op_reg == OP_ALLOC && !fail) ? SLOT_W'(alloc_idx) : '0;
        end
    end

    assign sts.out_busy  = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;

endmodule
